/* hw/rtl/hidkb_pkg.sv */
package hidkb_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_REPORT  = 2'd2;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND      = 2'd1;
    localparam logic [1:0] ST_NOT_CONFIGURED = 2'd2;
    localparam logic [1:0] ST_TOO_MANY       = 2'd3;

    // The boot report always carries six key slots.
    localparam int REPORT_KEYS = 6;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] usage_code;
        logic [7:0] modifiers;
        logic       link_configured;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] report_modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
        logic       report_changed;
    } t_out_word;

    // Commands from the sequencer to the key list and the report store.
    typedef struct packed {
        logic append;
        logic remove;
        logic store_last;
        logic done;
    } t_list_cmd;

endpackage

/* hw/rtl/hidkb_keylist.sv */
module hidkb_keylist
    import hidkb_pkg::*;
#(
    parameter int KEY_SLOTS = 6,
    parameter int IDXW      = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_list_cmd                          i_cmd,
    input  logic [IDXW-1:0]                    i_idx,
    input  logic [7:0]                         i_code,
    output logic [7:0]                         o_rd_data,
    output logic [$clog2(KEY_SLOTS+1)-1:0]     o_count,
    output logic [REPORT_KEYS-1:0][7:0]        o_rpt_slots
);

    localparam int CW = $clog2(KEY_SLOTS + 1);
    localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic [7:0]    r_slots [KEY_SLOTS];
    logic [7:0]    n_slots [KEY_SLOTS];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Single read port shared by the search and the report compare.
    assign o_rd_data = (i_idx < IDXW'(KEY_SLOTS)) ? r_slots[i_idx[IW-1:0]] : 8'd0;
    assign o_count   = r_count;

    always_comb begin
        n_slots = r_slots;
        n_count = r_count;
        if (i_cmd.append && (r_count < CW'(KEY_SLOTS))) begin
            n_slots[r_count[IW-1:0]] = i_code;
            n_count = r_count + 1'b1;
        end
        if (i_cmd.remove) begin
            // Every entry from the removed one upward moves down one place.
            for (int i = 0; i < KEY_SLOTS - 1; i++) begin
                if (IDXW'(i) >= i_idx) begin
                    n_slots[i] = r_slots[i+1];
                end
            end
            n_slots[KEY_SLOTS-1] = 8'd0;
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_slots[i] <= 8'd0;
            end
            r_count <= '0;
        end else begin
            r_slots <= n_slots;
            r_count <= n_count;
        end
    end

    for (genvar k = 0; k < REPORT_KEYS; k++) begin : g_rpt
        if (k < KEY_SLOTS) begin : g_used
            assign o_rpt_slots[k] = r_slots[k];
        end else begin : g_empty
            assign o_rpt_slots[k] = 8'd0;
        end
    end

endmodule

/* hw/rtl/hidkb_ctrl.sv */
module hidkb_ctrl
    import hidkb_pkg::*;
#(
    parameter int KEY_SLOTS = 6,
    parameter int IDXW      = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [1:0]                     i_op,
    input  logic [7:0]                     i_code,
    input  logic                           i_cfg,
    input  logic [7:0]                     i_mods,
    input  logic [$clog2(KEY_SLOTS+1)-1:0] i_count,
    input  logic [7:0]                     i_slot_data,
    input  logic [7:0]                     i_last_byte,
    input  logic                           i_out_free,
    output logic                           o_idle,
    output logic [IDXW-1:0]                o_rd_idx,
    output logic [2:0]                     o_last_idx,
    output t_list_cmd                      o_cmd,
    output logic [1:0]                     o_status,
    output logic                           o_changed
);

    localparam int CW = $clog2(KEY_SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RPT  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]      r_state;
    logic [1:0]      n_state;
    logic [IDXW-1:0] r_idx;
    logic [IDXW-1:0] n_idx;
    logic [1:0]      r_op;
    logic [1:0]      n_op;
    logic [1:0]      r_status;
    logic [1:0]      n_status;
    logic            r_changed;
    logic            n_changed;

    logic [7:0] w_opa;
    logic [7:0] w_opb;
    logic       w_eq;
    logic       w_in_list;
    logic       w_full;
    logic [1:0] w_cfg_ok;

    // The one byte comparator, fed from the list or from the report store.
    assign w_opa = (r_state == S_RPT) ? ((r_idx == '0) ? i_mods : i_slot_data) : i_slot_data;
    assign w_opb = (r_state == S_RPT) ? i_last_byte : i_code;
    assign w_eq  = (w_opa == w_opb);

    assign w_in_list = r_idx < IDXW'(i_count);
    assign w_full    = i_count >= CW'(KEY_SLOTS);
    assign w_cfg_ok  = i_cfg ? ST_OK : ST_NOT_CONFIGURED;

    assign o_rd_idx   = (r_state == S_RPT) ? r_idx - 1'b1 : r_idx;
    assign o_last_idx = r_idx[2:0];
    assign o_idle     = (r_state == S_IDLE);
    assign o_status   = r_status;
    assign o_changed  = r_changed;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_op      = r_op;
        n_status  = r_status;
        n_changed = r_changed;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op      = i_op;
                    n_idx     = '0;
                    n_status  = ST_OK;
                    n_changed = 1'b0;
                    if (i_op == OP_PRESS || i_op == OP_RELEASE) begin
                        n_state = S_SCAN;
                    end else if (i_op == OP_REPORT) begin
                        n_state = S_RPT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (i_code == 8'd0) begin
                    n_status = w_cfg_ok;
                    n_state  = S_OUT;
                end else if (w_in_list && w_eq) begin
                    o_cmd.remove = (r_op == OP_RELEASE);
                    n_status     = w_cfg_ok;
                    n_state      = S_OUT;
                end else if (w_in_list) begin
                    n_idx = r_idx + 1'b1;
                end else if (r_op == OP_PRESS) begin
                    if (w_full) begin
                        n_status = i_cfg ? ST_TOO_MANY : ST_NOT_CONFIGURED;
                    end else begin
                        o_cmd.append = 1'b1;
                        n_status     = w_cfg_ok;
                    end
                    n_state = S_OUT;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_OUT;
                end
            end
            S_RPT: begin
                if (!w_eq) begin
                    o_cmd.store_last = 1'b1;
                    n_changed        = 1'b1;
                    n_state          = S_OUT;
                end else if (r_idx == IDXW'(REPORT_KEYS)) begin
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_op      <= OP_PRESS;
            r_status  <= ST_OK;
            r_changed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_op      <= n_op;
            r_status  <= n_status;
            r_changed <= n_changed;
        end
    end

endmodule

/* hw/rtl/hid_keyboard_report_builder_top.sv */
// A key event scans the key list, a report request compares the report with the last one sent,
// and the unused op goes straight to the output. The single byte comparator
// walks the key list (or the seven report bytes) one entry per cycle until it hits a match
// or a difference, or reaches the end. Words are taken one at a time; the next word is accepted
// once its result is parked in the output register.
// Reset: synchronous, active low; clears the key list, count, modifiers and last report.
module hid_keyboard_report_builder_top
    import hidkb_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // The count needs one value beyond the slot count; the scan index must also
    // reach the seven bytes of the report compare.
    localparam int CW   = $clog2(KEY_SLOTS + 1);
    localparam int IDXW = (CW > 3) ? CW : 3;

    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_idle;
    logic [IDXW-1:0]             w_rd_idx;
    logic [2:0]                  w_last_idx;
    t_list_cmd                   w_cmd;
    logic [1:0]                  w_status;
    logic                        w_changed;
    logic [7:0]                  w_rd_data;
    logic [CW-1:0]               w_count;
    logic [REPORT_KEYS-1:0][7:0] w_rpt_slots;

    // Captured fields of the word being worked on.
    logic [7:0] r_code;
    logic       r_cfg;
    // Modifier byte of the current report.
    logic [7:0] r_mods;
    // Last report sent: the modifier byte followed by the six key slots. The
    // reserved byte of the boot report is always zero and is not kept.
    logic [7:0] r_last [REPORT_KEYS+1];
    // Output register that parks one finished result.
    logic       r_out_valid;
    t_out_word  r_out_word;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = w_idle;
    // The sequencer may hand over its result when no result is parked or the parked one leaves now.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_code <= i_in_word.usage_code;
            r_cfg  <= i_in_word.link_configured;
        end
    end

    // A press or release writes the modifier byte before anything else.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods <= 8'd0;
        end else if (w_in_acc && (i_in_word.op == OP_PRESS || i_in_word.op == OP_RELEASE)) begin
            r_mods <= i_in_word.modifiers;
        end
    end

    // A report that differs from the last one sent replaces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= REPORT_KEYS; i++) begin
                r_last[i] <= 8'd0;
            end
        end else if (w_cmd.store_last) begin
            r_last[0] <= r_mods;
            for (int i = 0; i < REPORT_KEYS; i++) begin
                r_last[i+1] <= w_rpt_slots[i];
            end
        end
    end

    hidkb_ctrl #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDXW      (IDXW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_acc),
        .i_op        (i_in_word.op),
        .i_code      (r_code),
        .i_cfg       (r_cfg),
        .i_mods      (r_mods),
        .i_count     (w_count),
        .i_slot_data (w_rd_data),
        .i_last_byte (r_last[w_last_idx]),
        .i_out_free  (w_out_free),
        .o_idle      (w_idle),
        .o_rd_idx    (w_rd_idx),
        .o_last_idx  (w_last_idx),
        .o_cmd       (w_cmd),
        .o_status    (w_status),
        .o_changed   (w_changed)
    );

    hidkb_keylist #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDXW      (IDXW)
    ) u_keylist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (w_rd_idx),
        .i_code      (r_code),
        .o_rd_data   (w_rd_data),
        .o_count     (w_count),
        .o_rpt_slots (w_rpt_slots)
    );

    // The list has settled by the time the sequencer signals done, so the
    // result word takes the key slots straight from the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.done) begin
            r_out_word.status           <= w_status;
            r_out_word.report_modifiers <= r_mods;
            r_out_word.key_slot_0       <= w_rpt_slots[0];
            r_out_word.key_slot_1       <= w_rpt_slots[1];
            r_out_word.key_slot_2       <= w_rpt_slots[2];
            r_out_word.key_slot_3       <= w_rpt_slots[3];
            r_out_word.key_slot_4       <= w_rpt_slots[4];
            r_out_word.key_slot_5       <= w_rpt_slots[5];
            r_out_word.report_changed   <= w_changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // The list never holds more codes than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(KEY_SLOTS))
        else $error("key count exceeds slot count");

    // An append grows the list by exactly one code.
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.append |=> w_count == $past(w_count) + 1'b1)
        else $error("append did not grow the key list");

    // A word is never added and removed in the same step.
    a_one_list_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.append && w_cmd.remove))
        else $error("append and remove at once");

    // Once a word is taken, the block is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("ready right after an accepted word");
`endif

endmodule
